// File: rtl/core/mmh_pkg.sv
// Shared constants and types for the multichannel min/max hold block.
package mmh_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int SAMPLE_BITS  = 16;
  localparam int CH_W         = 4;
  localparam int THR_W        = 14;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CMP_W        = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;

  localparam logic [THR_W-1:0] THRESH_MAX = THR_W'(12000);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MOST_NEG =
    {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MOST_POS =
    {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  // Input and output stream tdata widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic [CH_W-1:0]               channel;
    logic signed [SAMPLE_BITS-1:0] sample_mv;
    logic                          first_in_frame;
    logic                          last_in_frame;
    logic                          reset_button;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0]               channel_out;
    logic signed [SAMPLE_BITS-1:0] held_max_mv;
    logic signed [SAMPLE_BITS-1:0] held_min_mv;
    logic                          over_flag;
    logic                          under_flag;
    logic                          frame_done;
  } result_t;

endpackage

// File: rtl/core/mmh_in_reg.sv
// Input register stage: captures one sample transaction ahead of the update logic.
module mmh_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mmh_pkg::item_t in_item,
  input  logic          advance,
  output logic          stage_valid,
  output mmh_pkg::item_t stage_item
);

  logic           valid_r;
  logic           valid_nxt;
  mmh_pkg::item_t item_r;

  // take a new transaction when empty or when the held one moves on
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

endmodule

// File: rtl/core/mmh_update.sv
// Per-channel min/max stores, reset-edge clear and running over/under flags.
module mmh_update (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  mmh_pkg::item_t              item,
  input  logic [mmh_pkg::THR_W-1:0]   thr,
  output mmh_pkg::result_t            result
);

  logic signed [mmh_pkg::SAMPLE_BITS-1:0] max_r   [mmh_pkg::NUM_CHANNELS];
  logic signed [mmh_pkg::SAMPLE_BITS-1:0] min_r   [mmh_pkg::NUM_CHANNELS];
  logic signed [mmh_pkg::SAMPLE_BITS-1:0] max_nxt [mmh_pkg::NUM_CHANNELS];
  logic signed [mmh_pkg::SAMPLE_BITS-1:0] min_nxt [mmh_pkg::NUM_CHANNELS];
  logic prev_lvl_r, prev_lvl_nxt;
  logic over_r, over_nxt;
  logic under_r, under_nxt;

  logic                                   clr;
  logic                                   in_range;
  logic [mmh_pkg::CH_IDX_W-1:0]           idx;
  logic signed [mmh_pkg::SAMPLE_BITS-1:0] cur_max, cur_min;
  logic signed [mmh_pkg::SAMPLE_BITS-1:0] new_max, new_min;
  logic signed [mmh_pkg::CMP_W-1:0]       thr_s, nthr_s, max_x, min_x;
  logic                                   over_base, under_base;

  always_comb begin
    clr      = item.first_in_frame && item.reset_button && !prev_lvl_r;
    in_range = int'(item.channel) < mmh_pkg::NUM_CHANNELS;
    idx      = item.channel[mmh_pkg::CH_IDX_W-1:0];

    // a button edge clears every channel before this sample lands
    cur_max = clr ? mmh_pkg::SAMPLE_MOST_NEG : max_r[idx];
    cur_min = clr ? mmh_pkg::SAMPLE_MOST_POS : min_r[idx];
    new_max = (item.sample_mv > cur_max) ? item.sample_mv : cur_max;
    new_min = (item.sample_mv < cur_min) ? item.sample_mv : cur_min;

    thr_s  = signed'({{(mmh_pkg::CMP_W-mmh_pkg::THR_W){1'b0}}, thr});
    nthr_s = -thr_s;
    max_x  = mmh_pkg::CMP_W'(new_max);
    min_x  = mmh_pkg::CMP_W'(new_min);

    over_base  = item.first_in_frame ? 1'b0 : over_r;
    under_base = item.first_in_frame ? 1'b0 : under_r;
    over_nxt   = over_base  || (in_range && (max_x > thr_s));
    under_nxt  = under_base || (in_range && (min_x < nthr_s));

    prev_lvl_nxt = item.first_in_frame ? item.reset_button : prev_lvl_r;

    for (int i = 0; i < mmh_pkg::NUM_CHANNELS; i++) begin
      if (in_range && (idx == mmh_pkg::CH_IDX_W'(i))) begin
        max_nxt[i] = new_max;
        min_nxt[i] = new_min;
      end else if (clr) begin
        max_nxt[i] = mmh_pkg::SAMPLE_MOST_NEG;
        min_nxt[i] = mmh_pkg::SAMPLE_MOST_POS;
      end else begin
        max_nxt[i] = max_r[i];
        min_nxt[i] = min_r[i];
      end
    end

    result.channel_out = item.channel;
    result.held_max_mv = in_range ? new_max : mmh_pkg::SAMPLE_MOST_NEG;
    result.held_min_mv = in_range ? new_min : mmh_pkg::SAMPLE_MOST_POS;
    result.over_flag   = over_nxt;
    result.under_flag  = under_nxt;
    result.frame_done  = item.last_in_frame;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mmh_pkg::NUM_CHANNELS; i++) begin
        max_r[i] <= mmh_pkg::SAMPLE_MOST_NEG;
        min_r[i] <= mmh_pkg::SAMPLE_MOST_POS;
      end
      prev_lvl_r <= 1'b0;
      over_r     <= 1'b0;
      under_r    <= 1'b0;
    end else if (fire) begin
      for (int i = 0; i < mmh_pkg::NUM_CHANNELS; i++) begin
        max_r[i] <= max_nxt[i];
        min_r[i] <= min_nxt[i];
      end
      prev_lvl_r <= prev_lvl_nxt;
      over_r     <= over_nxt;
      under_r    <= under_nxt;
    end
  end

endmodule

// File: rtl/core/multichannel_min_max_hold.sv
// Pipe: input register, update logic, result register, from which the result is sent.
// Throughput: one sample per cycle while the result is not stalled.
// A stalled result holds the pipe; the input register still takes one more sample.
// Reset (rst_n low, synchronous): all channels cleared to max -32768 / min 32767,
// flags and button level cleared, threshold back to 12000.
// Configuration writes are taken every cycle (cfg_ready is always high).
module multichannel_min_max_hold (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [3:0] channel, [19:4] sample_mv, [20] reset_button, [23:21] zero
  input  logic [mmh_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] first_in_frame
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [3:0] channel_out, [19:4] held_max_mv, [35:20] held_min_mv,
  // [36] over_flag, [37] under_flag, [39:38] zero
  output logic [mmh_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mmh_pkg::THR_W-1:0]       cfg_data
);

  mmh_pkg::item_t   in_item;
  mmh_pkg::item_t   stage_item;
  mmh_pkg::result_t upd_result;
  mmh_pkg::result_t res_r;
  logic             stage_valid;
  logic             advance;
  logic             out_valid_r, out_valid_nxt;
  logic [mmh_pkg::THR_W-1:0] thr_r;
  logic [mmh_pkg::THR_W-1:0] thr_eff;

  always_comb begin
    in_item.channel        = in_tdata[3:0];
    in_item.sample_mv      = signed'(in_tdata[19:4]);
    in_item.reset_button   = in_tdata[20];
    in_item.first_in_frame = in_tuser;
    in_item.last_in_frame  = in_tlast;
  end

  // move the staged sample into the result register when it is free
  assign advance = !out_valid_r || out_tready;

  mmh_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  // out-of-range thresholds act as the maximum
  assign thr_eff = (thr_r > mmh_pkg::THRESH_MAX) ? mmh_pkg::THRESH_MAX : thr_r;

  mmh_update u_update (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (stage_valid && advance),
    .item   (stage_item),
    .thr    (thr_eff),
    .result (upd_result)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= mmh_pkg::THRESH_MAX;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      res_r <= upd_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.under_flag, res_r.over_flag,
                       res_r.held_min_mv, res_r.held_max_mv, res_r.channel_out};
  assign out_tlast  = res_r.frame_done;

endmodule

// File: tb/tb_multichannel_min_max_hold.sv
// Self-checking testbench for the multichannel min/max hold block.
`timescale 1ns / 100ps

module tb_multichannel_min_max_hold;

  localparam int RAND_PHASE_ITEMS = 125;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int IDLE_PCT         = 11;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [mmh_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           in_tuser = 1'b0;
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b1;
  logic [mmh_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tlast;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mmh_pkg::THR_W-1:0]      cfg_data = '0;

  // Samples waiting to be driven, and hold results still to arrive
  mmh_pkg::item_t   sample_q[$];
  mmh_pkg::result_t hold_result_q[$];

  int n_queued    = 0;
  int n_sent      = 0;
  int n_accepted  = 0;
  int n_checked   = 0;
  int n_frames    = 0;
  int n_settings  = 0;
  int err_count   = 0;
  int cycle_count = 0;
  bit no_idle     = 1'b0;

  // Shadow state of the block
  int                        hold_max[mmh_pkg::NUM_CHANNELS];
  int                        hold_min[mmh_pkg::NUM_CHANNELS];
  bit                        prev_btn;
  bit                        over_run;
  bit                        under_run;
  logic [mmh_pkg::THR_W-1:0] thr_copy;

  mmh_pkg::item_t   drive_item;
  mmh_pkg::item_t   bus_item;
  mmh_pkg::result_t exp_r;
  mmh_pkg::result_t got_r;

  multichannel_min_max_hold DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_holds();
    for (int i = 0; i < mmh_pkg::NUM_CHANNELS; i++) begin
      hold_max[i] = int'(mmh_pkg::SAMPLE_MOST_NEG);
      hold_min[i] = int'(mmh_pkg::SAMPLE_MOST_POS);
    end
  endfunction

  function automatic mmh_pkg::result_t predict_hold(mmh_pkg::item_t it);
    mmh_pkg::result_t r;
    int               thr_eff;
    int               s;
    int               hmax;
    int               hmin;
    thr_eff = (thr_copy > mmh_pkg::THRESH_MAX) ? int'(mmh_pkg::THRESH_MAX) : int'(thr_copy);
    s       = int'($signed(it.sample_mv));
    hmax    = int'(mmh_pkg::SAMPLE_MOST_NEG);
    hmin    = int'(mmh_pkg::SAMPLE_MOST_POS);
    if (it.first_in_frame) begin
      // rising button level clears every channel before this sample lands
      if (it.reset_button && !prev_btn) clear_holds();
      prev_btn  = it.reset_button;
      over_run  = 1'b0;
      under_run = 1'b0;
    end
    if (int'(it.channel) < mmh_pkg::NUM_CHANNELS) begin
      if (s > hold_max[it.channel]) hold_max[it.channel] = s;
      if (s < hold_min[it.channel]) hold_min[it.channel] = s;
      hmax = hold_max[it.channel];
      hmin = hold_min[it.channel];
      if (hmax > thr_eff) over_run = 1'b1;
      if (hmin < -thr_eff) under_run = 1'b1;
    end
    r.channel_out = it.channel;
    r.held_max_mv = hmax[mmh_pkg::SAMPLE_BITS-1:0];
    r.held_min_mv = hmin[mmh_pkg::SAMPLE_BITS-1:0];
    r.over_flag   = over_run;
    r.under_flag  = under_run;
    r.frame_done  = it.last_in_frame;
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  task automatic add_sample(input logic [mmh_pkg::CH_W-1:0] ch,
                            input logic [mmh_pkg::SAMPLE_BITS-1:0] s,
                            input bit first, input bit last, input bit btn);
    mmh_pkg::item_t it;
    it.channel        = ch;
    it.sample_mv      = s;
    it.first_in_frame = first;
    it.last_in_frame  = last;
    it.reset_button   = btn;
    sample_q.push_back(it);
    n_queued++;
  endtask

  function automatic logic [mmh_pkg::SAMPLE_BITS-1:0] pick_sample(input int thr);
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = int'($signed(mmh_pkg::SAMPLE_BITS'($urandom)));
      4, 5:       v = thr + int'($urandom_range(6)) - 3;
      6, 7:       v = -thr + int'($urandom_range(6)) - 3;
      8:          v = $urandom_range(1) ? int'(mmh_pkg::SAMPLE_MOST_POS)
                                        : int'(mmh_pkg::SAMPLE_MOST_NEG);
      default:    v = int'($urandom_range(200)) - 100;
    endcase
    if (v > int'(mmh_pkg::SAMPLE_MOST_POS)) v = int'(mmh_pkg::SAMPLE_MOST_POS);
    if (v < int'(mmh_pkg::SAMPLE_MOST_NEG)) v = int'(mmh_pkg::SAMPLE_MOST_NEG);
    return v[mmh_pkg::SAMPLE_BITS-1:0];
  endfunction

  // One frame of samples; a noisy frame scrambles the frame marks
  task automatic add_random_frame(input int thr, output int count);
    int                       len;
    int                       base;
    bit                       seq;
    bit                       noisy;
    bit                       btn;
    bit                       first;
    bit                       last;
    logic [mmh_pkg::CH_W-1:0] ch;
    len   = ($urandom_range(9) == 0) ? mmh_pkg::NUM_CHANNELS : int'($urandom_range(1, 8));
    seq   = ($urandom_range(1) == 1);
    base  = $urandom_range(mmh_pkg::NUM_CHANNELS - 1);
    noisy = ($urandom_range(99) < 15);
    btn   = ($urandom_range(2) == 0);
    for (int i = 0; i < len; i++) begin
      ch    = seq ? mmh_pkg::CH_W'(base + i)
                  : mmh_pkg::CH_W'($urandom_range(mmh_pkg::NUM_CHANNELS - 1));
      first = (i == 0);
      last  = (i == len - 1);
      if (noisy) begin
        first = ($urandom_range(3) == 0);
        last  = ($urandom_range(3) == 0);
      end
      add_sample(ch, pick_sample(thr), first, last, first ? btn : bit'($urandom_range(1)));
    end
    n_frames++;
    count = len;
  endtask

  task automatic write_threshold(input logic [mmh_pkg::THR_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Hold off until every queued sample is taken and every result checked
  task automatic wait_drained();
    @(negedge clk);
    while (n_accepted != n_queued || hold_result_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic run_random_phase(input logic [mmh_pkg::THR_W-1:0] thr, input bit burst);
    int added;
    int got;
    int thr_eff;
    write_threshold(thr);
    thr_eff = (thr > mmh_pkg::THRESH_MAX) ? int'(mmh_pkg::THRESH_MAX) : int'(thr);
    @(posedge clk);
    no_idle = burst;
    added   = 0;
    while (added < RAND_PHASE_ITEMS) begin
      add_random_frame(thr_eff, got);
      added += got;
    end
    wait_drained();
    no_idle = 1'b0;
  endtask

  // Driver: present the next sample once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b1;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      if (!in_tvalid || n_accepted == n_sent) begin
        if (sample_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          drive_item = sample_q.pop_front();
          n_sent++;
          in_tvalid <= 1'b1;
          in_tdata  <= {3'b000, drive_item.reset_button, drive_item.sample_mv,
                        drive_item.channel};
          in_tuser  <= drive_item.first_in_frame;
          in_tlast  <= drive_item.last_in_frame;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on each accepted sample, compare each accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_holds();
      prev_btn  = 1'b0;
      over_run  = 1'b0;
      under_run = 1'b0;
      thr_copy  = mmh_pkg::THRESH_MAX;
    end else begin
      if (cfg_valid && cfg_ready) thr_copy = cfg_data;
      if (in_tvalid && in_tready) begin
        bus_item.channel        = in_tdata[3:0];
        bus_item.sample_mv      = in_tdata[19:4];
        bus_item.reset_button   = in_tdata[20];
        bus_item.first_in_frame = in_tuser;
        bus_item.last_in_frame  = in_tlast;
        hold_result_q.push_back(predict_hold(bus_item));
        n_accepted++;
      end
      if (out_tvalid && out_tready) begin
        got_r.channel_out = out_tdata[3:0];
        got_r.held_max_mv = out_tdata[19:4];
        got_r.held_min_mv = out_tdata[35:20];
        got_r.over_flag   = out_tdata[36];
        got_r.under_flag  = out_tdata[37];
        got_r.frame_done  = out_tlast;
        if (hold_result_q.size() == 0) begin
          $error("result transaction with nothing pending, channel_out %0d",
                 got_r.channel_out);
          err_count++;
        end else begin
          exp_r = hold_result_q.pop_front();
          check_field("channel_out", exp_r.channel_out, got_r.channel_out);
          check_field("held_max_mv", exp_r.held_max_mv, got_r.held_max_mv);
          check_field("held_min_mv", exp_r.held_min_mv, got_r.held_min_mv);
          check_field("over_flag", exp_r.over_flag, got_r.over_flag);
          check_field("under_flag", exp_r.under_flag, got_r.under_flag);
          check_field("frame_done", exp_r.frame_done, got_r.frame_done);
          n_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset threshold of 12000
    add_sample(4'd0, 16'sd0, 1'b1, 1'b0, 1'b1);           // button edge clears all
    add_sample(4'd15, mmh_pkg::SAMPLE_MOST_POS, 1'b0, 1'b0, 1'b0);
    add_sample(4'd1, mmh_pkg::SAMPLE_MOST_NEG, 1'b0, 1'b1, 1'b0);
    add_sample(4'd0, 16'sd12000, 1'b1, 1'b0, 1'b1);       // level held: no clear
    add_sample(4'd0, 16'sd12001, 1'b0, 1'b0, 1'b0);
    add_sample(4'd2, -16'sd12000, 1'b0, 1'b0, 1'b0);
    add_sample(4'd2, -16'sd12001, 1'b0, 1'b1, 1'b0);
    add_sample(4'd3, 16'sd100, 1'b0, 1'b0, 1'b1);         // button ignored mid-frame
    add_sample(4'd3, -16'sd1, 1'b1, 1'b0, 1'b0);
    add_sample(4'd4, mmh_pkg::SAMPLE_MOST_NEG, 1'b0, 1'b1, 1'b0);
    add_sample(4'd5, 16'sd5, 1'b1, 1'b0, 1'b1);           // new edge clears all
    add_sample(4'd15, 16'sd0, 1'b0, 1'b0, 1'b0);
    add_sample(4'd1, 16'sd1, 1'b1, 1'b1, 1'b0);           // single-sample frame
    add_sample(4'd6, 16'sd7, 1'b0, 1'b1, 1'b0);           // last without first
    add_sample(4'd6, -16'sd7, 1'b0, 1'b1, 1'b1);
    add_sample(4'd7, mmh_pkg::SAMPLE_MOST_POS, 1'b1, 1'b0, 1'b0);  // first without last
    add_sample(4'd7, mmh_pkg::SAMPLE_MOST_NEG, 1'b1, 1'b0, 1'b0);
    add_sample(4'd8, -16'sd1, 1'b0, 1'b0, 1'b0);
    add_sample(4'd9, 16'sd12000, 1'b0, 1'b1, 1'b0);
    add_sample(4'd10, 16'h5555, 1'b1, 1'b1, 1'b1);
    add_sample(4'd11, 16'shAAAA, 1'b1, 1'b1, 1'b0);
    n_frames += 12;
    wait_drained();

    // Random part: threshold settings include 0, the maximum of 12000 and two above range
    run_random_phase(mmh_pkg::THR_W'(0), 1'b0);
    run_random_phase(mmh_pkg::THR_W'(16383), 1'b1);
    run_random_phase(mmh_pkg::THR_W'($urandom_range(1, 11999)), 1'b0);
    run_random_phase(mmh_pkg::THR_W'($urandom_range(12001, 16383)), 1'b0);
    run_random_phase(mmh_pkg::THRESH_MAX, 1'b0);

    $display("tb: %0d samples in %0d frames over %0d threshold writes, %0d results checked",
             n_accepted, n_frames, n_settings, n_checked);
    $display("tb: button edges, held levels, scrambled frame marks and stalls on both sides");
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
